[src/triangle_normal_and_bounds_assert.svh]
// Assertion macros for the triangle normal and bounds block.
// Used by the top level; no other dependencies.
`ifndef TRIANGLE_NORMAL_AND_BOUNDS_ASSERT_SVH
`define TRIANGLE_NORMAL_AND_BOUNDS_ASSERT_SVH
`ifndef SYNTHESIS
`define TNB_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TNB_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TNB_ASSERT_CLK(label, prop, msg)
`define TNB_ASSERT_NEVER(label, expr, msg)
`endif
`endif

[src/tnb_pkg.sv]
// Shared constants, state types and control struct for the triangle normal block.
// No dependencies.
package tnb_pkg;
  localparam int COORD_BITS_DEF       = 32;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int MAG_BITS             = 30;
  localparam int BIG_SHIFT            = 8;
  localparam int SQ_STEPS             = 31;
  localparam int NORM_W               = 16;

  typedef enum logic [3:0] {
    NS_IDLE, NS_MUL, NS_MAG, NS_SHIFT, NS_SQ, NS_SQRT, NS_PREP, NS_DIV, NS_DONE
  } norm_state_t;

  typedef enum logic [1:0] {TS_IDLE, TS_BUSY, TS_OUT} top_state_t;

  typedef struct packed {
    logic start;
    logic tri_f;
    logic ack;
  } norm_ctl_t;
endpackage

[src/tnb_box.sv]
// Running axis-aligned box: one vertex compared per cycle on all three axes.
// Depends on tnb_pkg for nothing beyond the coordinate width handed down.
module tnb_box #(
  parameter int CB = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 tri_f,
  input  logic                 clear,
  input  logic signed [CB-1:0] vtx [9],
  output logic signed [CB-1:0] low [3],
  output logic signed [CB-1:0] high [3],
  output logic                 busy
);
  localparam logic signed [CB-1:0] MOST_POS = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] MOST_NEG = {1'b1, {(CB-1){1'b0}}};

  logic signed [CB-1:0] vr_r [9];
  logic signed [CB-1:0] low_r [3];
  logic signed [CB-1:0] high_r [3];
  logic [1:0]           left_r;

  always_ff @(posedge clk) begin
    if (start) begin
      vr_r <= vtx;
    end else if (left_r != 2'd0) begin
      // shift the next vertex into the compare slot
      for (int i = 0; i < 6; i++) vr_r[i] <= vr_r[i+3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        low_r[i]  <= MOST_POS;
        high_r[i] <= MOST_NEG;
      end
    end else begin
      if (start) begin
        left_r <= tri_f ? 2'd3 : 2'd0;
      end else if (left_r != 2'd0) begin
        left_r <= left_r - 2'd1;
        for (int i = 0; i < 3; i++) begin
          if (vr_r[i] < low_r[i])  low_r[i]  <= vr_r[i];
          if (vr_r[i] > high_r[i]) high_r[i] <= vr_r[i];
        end
      end
      if (clear) begin
        for (int i = 0; i < 3; i++) begin
          low_r[i]  <= MOST_POS;
          high_r[i] <= MOST_NEG;
        end
      end
    end
  end

  assign low  = low_r;
  assign high = high_r;
  assign busy = (left_r != 2'd0);
endmodule

[src/tnb_normal.sv]
// Unit normal sequencer: one shared multiplier, bit-serial square root and divider.
// Depends on tnb_pkg (state type, control struct, constants).
module tnb_normal #(
  parameter int CB = 32,
  parameter int NF = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tnb_pkg::norm_ctl_t   ctl,
  input  logic signed [CB-1:0] va [3],
  input  logic signed [CB-1:0] vb [3],
  input  logic signed [CB-1:0] vc [3],
  output logic                 done,
  output logic [tnb_pkg::NORM_W-1:0] nrm [3]
);
  localparam int DW = CB + 1;
  localparam int MW = (DW > 31) ? DW : 31;
  localparam int PW = 2 * MW;
  localparam int XW = (2 * CB + 3 > 40) ? 2 * CB + 3 : 40;
  localparam int QW = 62;
  localparam int RW = 32;
  localparam int QB = NF + 2;
  localparam int VW = NF + 34;
  localparam int CW = 6;
  localparam int MB = tnb_pkg::MAG_BITS;
  localparam int NW = tnb_pkg::NORM_W;

  tnb_pkg::norm_state_t state_r, state_nxt;
  logic signed [DW-1:0] d1_r [3], d2_r [3], d1_nxt [3], d2_nxt [3];
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [XW-1:0] cr_r [3], cr_nxt [3];
  logic                 neg_r [3], neg_nxt [3];
  logic [QW-1:0]        q_r, q_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [VW-1:0]        rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [QB-1:0]        quo_r, quo_nxt;
  logic [1:0]           comp_r, comp_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [NW-1:0]        nrm_r [3], nrm_nxt [3];

  logic signed [MW-1:0] mul_a, mul_b;
  logic [XW-1:0]        orv;
  logic [QW-1:0]        rb;
  logic [RW-2:0]        rr;
  logic [MB-1:0]        msel;
  logic [QB-1:0]        qf, qc;
  logic signed [QB:0]   qs;
  logic                 ge;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    msel  = '0;
    case (cnt_r[1:0])
      2'd0:    msel = cr_r[0][MB-1:0];
      2'd1:    msel = cr_r[1][MB-1:0];
      2'd2:    msel = cr_r[2][MB-1:0];
      default: msel = '0;
    endcase
    if (state_r == tnb_pkg::NS_MUL) begin
      case (cnt_r)
        CW'(0): begin mul_a = MW'(d1_r[1]); mul_b = MW'(d2_r[2]); end
        CW'(1): begin mul_a = MW'(d1_r[2]); mul_b = MW'(d2_r[1]); end
        CW'(2): begin mul_a = MW'(d1_r[2]); mul_b = MW'(d2_r[0]); end
        CW'(3): begin mul_a = MW'(d1_r[0]); mul_b = MW'(d2_r[2]); end
        CW'(4): begin mul_a = MW'(d1_r[0]); mul_b = MW'(d2_r[1]); end
        CW'(5): begin mul_a = MW'(d1_r[1]); mul_b = MW'(d2_r[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == tnb_pkg::NS_SQ) begin
      mul_a = MW'($signed({1'b0, msel}));
      mul_b = MW'($signed({1'b0, msel}));
    end
    prod_nxt = mul_a * mul_b;
  end

  always_comb begin
    state_nxt = state_r;
    d1_nxt    = d1_r;
    d2_nxt    = d2_r;
    cr_nxt    = cr_r;
    neg_nxt   = neg_r;
    q_nxt     = q_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    rem_nxt   = rem_r;
    dsh_nxt   = dsh_r;
    quo_nxt   = quo_r;
    comp_nxt  = comp_r;
    cnt_nxt   = cnt_r;
    nrm_nxt   = nrm_r;
    orv       = cr_r[0] | cr_r[1] | cr_r[2];
    rb        = root_r + bit_r;
    rr        = (root_r[RW-2:0] == '0) ? (RW-1)'(1) : root_r[RW-2:0];
    ge        = (rem_r >= dsh_r);
    qf        = {quo_r[QB-2:0], ge};
    qc        = (qf > (QB'(1) << NF)) ? (QB'(1) << NF) : qf;
    qs        = neg_r[comp_r] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    case (state_r)
      tnb_pkg::NS_IDLE: begin
        if (ctl.start) begin
          for (int i = 0; i < 3; i++) begin
            d1_nxt[i]  = DW'(vb[i]) - DW'(va[i]);
            d2_nxt[i]  = DW'(vc[i]) - DW'(vb[i]);
            nrm_nxt[i] = '0;
          end
          cnt_nxt   = '0;
          state_nxt = ctl.tri_f ? tnb_pkg::NS_MUL : tnb_pkg::NS_DONE;
        end
      end
      tnb_pkg::NS_MUL: begin
        // product issued at cnt lands in the following cycle; odd ones are subtracted
        case (cnt_r)
          CW'(1): cr_nxt[0] = XW'(prod_r);
          CW'(2): cr_nxt[0] = cr_r[0] - XW'(prod_r);
          CW'(3): cr_nxt[1] = XW'(prod_r);
          CW'(4): cr_nxt[1] = cr_r[1] - XW'(prod_r);
          CW'(5): cr_nxt[2] = XW'(prod_r);
          CW'(6): cr_nxt[2] = cr_r[2] - XW'(prod_r);
          default: ;
        endcase
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(6)) state_nxt = tnb_pkg::NS_MAG;
      end
      tnb_pkg::NS_MAG: begin
        for (int i = 0; i < 3; i++) begin
          neg_nxt[i] = cr_r[i][XW-1];
          cr_nxt[i]  = cr_r[i][XW-1] ? -cr_r[i] : cr_r[i];
        end
        // degenerate: normal stays zero
        if (orv == '0) state_nxt = tnb_pkg::NS_DONE;
        else           state_nxt = tnb_pkg::NS_SHIFT;
      end
      tnb_pkg::NS_SHIFT: begin
        // big steps while far above the limit, then single bits; truncation composes
        if (|orv[XW-1:MB+tnb_pkg::BIG_SHIFT]) begin
          for (int i = 0; i < 3; i++) cr_nxt[i] = cr_r[i] >>> tnb_pkg::BIG_SHIFT;
        end else if (|orv[XW-1:MB]) begin
          for (int i = 0; i < 3; i++) cr_nxt[i] = cr_r[i] >>> 1;
        end else begin
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = tnb_pkg::NS_SQ;
        end
      end
      tnb_pkg::NS_SQ: begin
        if (cnt_r != CW'(0)) q_nxt = q_r + QW'(prod_r);
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(3)) begin
          root_nxt  = '0;
          bit_nxt   = QW'(1) << (QW - 2);
          cnt_nxt   = '0;
          state_nxt = tnb_pkg::NS_SQRT;
        end
      end
      tnb_pkg::NS_SQRT: begin
        if (q_r >= rb) begin
          q_nxt    = q_r - rb;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(tnb_pkg::SQ_STEPS - 1)) begin
          comp_nxt  = 2'd0;
          state_nxt = tnb_pkg::NS_PREP;
        end
      end
      tnb_pkg::NS_PREP: begin
        rem_nxt   = (VW'(cr_r[comp_r][MB-1:0]) << (NF + 1)) + VW'(rr);
        dsh_nxt   = VW'({rr, 1'b0}) << (QB - 1);
        quo_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = tnb_pkg::NS_DIV;
      end
      tnb_pkg::NS_DIV: begin
        if (ge) rem_nxt = rem_r - dsh_r;
        dsh_nxt = dsh_r >> 1;
        quo_nxt = qf;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(QB - 1)) begin
          nrm_nxt[comp_r] = NW'(qs);
          comp_nxt        = comp_r + 2'd1;
          state_nxt       = (comp_r == 2'd2) ? tnb_pkg::NS_DONE : tnb_pkg::NS_PREP;
        end
      end
      tnb_pkg::NS_DONE: begin
        if (ctl.ack) state_nxt = tnb_pkg::NS_IDLE;
      end
      default: state_nxt = tnb_pkg::NS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tnb_pkg::NS_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    d1_r   <= d1_nxt;
    d2_r   <= d2_nxt;
    prod_r <= prod_nxt;
    cr_r   <= cr_nxt;
    neg_r  <= neg_nxt;
    q_r    <= q_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quo_r  <= quo_nxt;
    comp_r <= comp_nxt;
    cnt_r  <= cnt_nxt;
    nrm_r  <= nrm_nxt;
  end

  assign done = (state_r == tnb_pkg::NS_DONE);
  assign nrm  = nrm_r;
endmodule

[src/triangle_normal_and_bounds.sv]
// Face normal and running bounding box, top level with the word handshakes.
// Depends on tnb_pkg, tnb_normal, tnb_box and the assertion macro header.
//
// One face word at a time. A face that is not a triangle skips the normal work
// and goes straight to its result word, and a degenerate triangle stops once
// its cross terms are all zero. A triangle runs through the shared multiplier
// (six cross terms, three squares), a shift stage that brings the cross
// magnitudes below 2^30 in steps of 8 or 1 bit, a one-bit-per-cycle square
// root of 31 steps and a restoring divider of NORMAL_FRAC_BITS+2 steps per
// component; the run time is set mostly by the square root and the three
// divides. The box is widened while the normal is worked out, and is returned
// to empty once the word with box_final set has been taken. in_ready is high
// only while no face is in progress and no result is waiting.
`include "triangle_normal_and_bounds_assert.svh"
module triangle_normal_and_bounds #(
  parameter int COORD_BITS       = tnb_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = tnb_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_ax,
  input  logic signed [COORD_BITS-1:0] in_ay,
  input  logic signed [COORD_BITS-1:0] in_az,
  input  logic signed [COORD_BITS-1:0] in_bx,
  input  logic signed [COORD_BITS-1:0] in_by,
  input  logic signed [COORD_BITS-1:0] in_bz,
  input  logic signed [COORD_BITS-1:0] in_cx,
  input  logic signed [COORD_BITS-1:0] in_cy,
  input  logic signed [COORD_BITS-1:0] in_cz,
  input  logic                         in_is_triangle,
  input  logic                         in_group_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [tnb_pkg::NORM_W-1:0] out_normal_x,
  output logic signed [tnb_pkg::NORM_W-1:0] out_normal_y,
  output logic signed [tnb_pkg::NORM_W-1:0] out_normal_z,
  output logic                         out_normal_valid,
  output logic signed [COORD_BITS-1:0] out_box_low_x,
  output logic signed [COORD_BITS-1:0] out_box_low_y,
  output logic signed [COORD_BITS-1:0] out_box_low_z,
  output logic signed [COORD_BITS-1:0] out_box_high_x,
  output logic signed [COORD_BITS-1:0] out_box_high_y,
  output logic signed [COORD_BITS-1:0] out_box_high_z,
  output logic                         out_box_final
);
  tnb_pkg::top_state_t state_r, state_nxt;
  tnb_pkg::norm_ctl_t  ctl;
  logic                tri_r, last_r;
  logic                in_acc, out_acc, norm_done, box_busy;
  logic [tnb_pkg::NORM_W-1:0] nrm [3];
  logic signed [COORD_BITS-1:0] va [3], vb [3], vc [3], vtx [9];
  logic signed [COORD_BITS-1:0] low [3], high [3];

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  assign va  = '{in_ax, in_ay, in_az};
  assign vb  = '{in_bx, in_by, in_bz};
  assign vc  = '{in_cx, in_cy, in_cz};
  assign vtx = '{in_ax, in_ay, in_az, in_bx, in_by, in_bz, in_cx, in_cy, in_cz};

  assign ctl.start = in_acc;
  assign ctl.tri_f = in_is_triangle;
  assign ctl.ack   = out_acc;

  tnb_normal #(.CB(COORD_BITS), .NF(NORMAL_FRAC_BITS)) u_normal (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .va(va), .vb(vb), .vc(vc),
    .done(norm_done), .nrm(nrm)
  );

  tnb_box #(.CB(COORD_BITS)) u_box (
    .clk(clk), .rst_n(rst_n), .start(in_acc), .tri_f(in_is_triangle),
    .clear(out_acc && last_r), .vtx(vtx), .low(low), .high(high), .busy(box_busy)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tnb_pkg::TS_IDLE: if (in_acc) state_nxt = tnb_pkg::TS_BUSY;
      tnb_pkg::TS_BUSY: if (norm_done) state_nxt = tnb_pkg::TS_OUT;
      tnb_pkg::TS_OUT:  if (out_acc) state_nxt = tnb_pkg::TS_IDLE;
      default:          state_nxt = tnb_pkg::TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tnb_pkg::TS_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tri_r  <= in_is_triangle;
      last_r <= in_group_end;
    end
  end

  assign in_ready         = (state_r == tnb_pkg::TS_IDLE);
  assign out_valid        = (state_r == tnb_pkg::TS_OUT);
  assign out_normal_x     = nrm[0];
  assign out_normal_y     = nrm[1];
  assign out_normal_z     = nrm[2];
  assign out_normal_valid = tri_r;
  assign out_box_low_x    = low[0];
  assign out_box_low_y    = low[1];
  assign out_box_low_z    = low[2];
  assign out_box_high_x   = high[0];
  assign out_box_high_y   = high[1];
  assign out_box_high_z   = high[2];
  assign out_box_final    = last_r;

  `TNB_ASSERT_NEVER(a_ready_while_out, in_ready && out_valid, "ready while result word waits")
  `TNB_ASSERT_CLK(a_box_before_norm, norm_done |-> !box_busy, "box still widening at normal done")
  `TNB_ASSERT_CLK(a_free_after_out, out_acc |=> in_ready, "not ready after result word taken")
endmodule

[dv/triangle_normal_and_bounds_tb.sv]
// Testbench for triangle_normal_and_bounds: face normals and running box.
// Self-checking against an in-bench predictor; needs tnb_pkg and the block only.
`timescale 1ns / 1ps

module triangle_normal_and_bounds_tb;
  localparam int CW = tnb_pkg::COORD_BITS_DEF;
  localparam int FB = tnb_pkg::NORMAL_FRAC_BITS_DEF;
  localparam int NW = tnb_pkg::NORM_W;
  localparam int N_RANDOM = 1230;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct {
    logic signed [CW-1:0] v[9];
    bit tri_f;
    bit last;
  } face_t;

  typedef struct {
    logic [NW-1:0] n[3];
    bit nvalid;
    logic [CW-1:0] lo[3];
    logic [CW-1:0] hi[3];
    bit fin;
  } face_result_t;

  class bounds_scoreboard;
    logic signed [CW-1:0] box_lo[3];
    logic signed [CW-1:0] box_hi[3];
    face_result_t pending[$];
    int errors;
    int checked;
    int triangles;
    int groups;

    function void clear_box();
      for (int i = 0; i < 3; i++) begin
        box_lo[i] = {1'b0, {(CW-1){1'b1}}};
        box_hi[i] = {1'b1, {(CW-1){1'b0}}};
      end
    endfunction

    function new();
      errors = 0;
      checked = 0;
      triangles = 0;
      groups = 0;
      clear_box();
    endfunction

    function longint unsigned isqrt(longint unsigned q);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > q) b = b >> 2;
      while (b != 0) begin
        if (q >= r + b) begin
          q = q - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Works out one face and queues its result word.
    function void note_face(face_t f);
      face_result_t e;
      logic signed [CW:0] d1[3];
      logic signed [CW:0] d2[3];
      logic signed [127:0] c[3];
      logic [127:0] mag[3];
      longint unsigned m[3];
      longint unsigned q, r, num, nv;
      int top, s;
      for (int i = 0; i < 3; i++) e.n[i] = '0;
      if (f.tri_f) begin
        triangles++;
        for (int i = 0; i < 3; i++) begin
          d1[i] = (CW+1)'(f.v[3+i]) - (CW+1)'(f.v[i]);
          d2[i] = (CW+1)'(f.v[6+i]) - (CW+1)'(f.v[3+i]);
        end
        c[0] = 128'(d1[1]) * 128'(d2[2]) - 128'(d1[2]) * 128'(d2[1]);
        c[1] = 128'(d1[2]) * 128'(d2[0]) - 128'(d1[0]) * 128'(d2[2]);
        c[2] = 128'(d1[0]) * 128'(d2[1]) - 128'(d1[1]) * 128'(d2[0]);
        top = 0;
        for (int i = 0; i < 3; i++) begin
          mag[i] = c[i] < 0 ? -c[i] : c[i];
          for (int b = 0; b < 128; b++) if (mag[i][b] && b + 1 > top) top = b + 1;
        end
        if (top != 0) begin
          s = top > tnb_pkg::MAG_BITS ? top - tnb_pkg::MAG_BITS : 0;
          for (int i = 0; i < 3; i++) m[i] = 64'(mag[i] >> s);
          q = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
          r = isqrt(q);
          if (r == 0) r = 1;
          for (int i = 0; i < 3; i++) begin
            num = ((m[i] << FB) << 1) + r;
            nv = num / (r << 1);
            if (nv > (64'd1 << FB)) nv = 64'd1 << FB;
            e.n[i] = c[i] < 0 ? NW'(-nv) : NW'(nv);
          end
        end
        for (int k = 0; k < 3; k++)
          for (int i = 0; i < 3; i++) begin
            if (f.v[3*k+i] < box_lo[i]) box_lo[i] = f.v[3*k+i];
            if (f.v[3*k+i] > box_hi[i]) box_hi[i] = f.v[3*k+i];
          end
      end
      for (int i = 0; i < 3; i++) begin
        e.lo[i] = box_lo[i];
        e.hi[i] = box_hi[i];
      end
      e.nvalid = f.tri_f;
      e.fin = f.last;
      if (f.last) begin
        groups++;
        clear_box();
      end
      pending = {pending, e};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch on word %0d: %s", checked, msg);
    endtask

    task check_word(face_result_t got);
      face_result_t e;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      e = pending.pop_front();
      checked++;
      for (int i = 0; i < 3; i++) begin
        if (got.n[i] !== e.n[i])
          report($sformatf("normal[%0d] got %h exp %h", i, got.n[i], e.n[i]));
        if (got.lo[i] !== e.lo[i])
          report($sformatf("box_low[%0d] got %h exp %h", i, got.lo[i], e.lo[i]));
        if (got.hi[i] !== e.hi[i])
          report($sformatf("box_high[%0d] got %h exp %h", i, got.hi[i], e.hi[i]));
      end
      if (got.nvalid !== e.nvalid) report("normal_valid mismatch");
      if (got.fin !== e.fin) report("box_final mismatch");
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_v[9];
  logic in_is_triangle = 1'b0;
  logic in_group_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [NW-1:0] out_nx, out_ny, out_nz;
  logic out_normal_valid, out_box_final;
  logic signed [CW-1:0] out_lx, out_ly, out_lz, out_hx, out_hy, out_hz;

  bounds_scoreboard sb = new();
  int send_idle_pct = 10;
  int recv_idle_pct = 76;
  bit hold_recv = 1'b0;
  longint cycles = 0;

  initial for (int i = 0; i < 9; i++) in_v[i] = '0;

  always #5 clk = ~clk;

  triangle_normal_and_bounds dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_ax(in_v[0]), .in_ay(in_v[1]), .in_az(in_v[2]),
    .in_bx(in_v[3]), .in_by(in_v[4]), .in_bz(in_v[5]),
    .in_cx(in_v[6]), .in_cy(in_v[7]), .in_cz(in_v[8]),
    .in_is_triangle(in_is_triangle), .in_group_end(in_group_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_normal_x(out_nx), .out_normal_y(out_ny), .out_normal_z(out_nz),
    .out_normal_valid(out_normal_valid),
    .out_box_low_x(out_lx), .out_box_low_y(out_ly), .out_box_low_z(out_lz),
    .out_box_high_x(out_hx), .out_box_high_y(out_hy), .out_box_high_z(out_hz),
    .out_box_final(out_box_final)
  );

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    face_result_t got;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      got.n[0] = out_nx;
      got.n[1] = out_ny;
      got.n[2] = out_nz;
      got.nvalid = out_normal_valid;
      got.lo[0] = out_lx;
      got.lo[1] = out_ly;
      got.lo[2] = out_lz;
      got.hi[0] = out_hx;
      got.hi[1] = out_hy;
      got.hi[2] = out_hz;
      got.fin = out_box_final;
      sb.check_word(got);
    end
    out_ready <= rst_n && !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return CW'($signed($urandom_range(2000)) - 1000) <<< 16;
      3: return CW'($signed($urandom_range(64)) - 32);
      default: return $urandom;
    endcase
  endfunction

  // Valid stays up straight into the next word when there is no idle gap.
  task automatic send_face(face_t f);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    for (int i = 0; i < 9; i++) in_v[i] <= f.v[i];
    in_is_triangle <= f.tri_f;
    in_group_end <= f.last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_face(f);
  endtask

  task automatic send_coords(logic [CW-1:0] c, bit t, bit l);
    face_t f;
    for (int i = 0; i < 9; i++) f.v[i] = c;
    f.tri_f = t;
    f.last = l;
    send_face(f);
  endtask

  task automatic send_random(int mode, bit t, bit l);
    face_t f;
    int md;
    md = mode;
    for (int i = 0; i < 9; i++) begin
      if (mode < 0) md = $urandom_range(4);
      f.v[i] = rand_coord(md);
    end
    f.tri_f = t;
    f.last = l;
    send_face(f);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  initial begin
    face_t f;
    int glen;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty group, skipped face ends group, extremes, degenerate
    send_coords('0, 1'b0, 1'b1);
    send_coords({1'b0, {(CW-1){1'b1}}}, 1'b1, 1'b0);
    send_coords({1'b1, {(CW-1){1'b0}}}, 1'b1, 1'b0);
    send_coords(32'h1234_5678, 1'b0, 1'b1);
    for (int i = 0; i < 9; i++) f.v[i] = '0;
    f.v[3] = 32'h0001_0000;
    f.v[7] = 32'h0001_0000;
    f.tri_f = 1'b1;
    f.last = 1'b0;
    send_face(f);
    // collinear corners
    for (int i = 0; i < 9; i++) f.v[i] = CW'(i / 3) <<< 16;
    send_face(f);
    for (int i = 0; i < 9; i++) f.v[i] = (i % 2) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
    f.last = 1'b1;
    send_face(f);
    for (int k = 0; k < 5; k++) send_random(k, 1'b1, k == 4);
    send_random(-1, 1'b0, 1'b0);
    send_random(4, 1'b1, 1'b1);
    // sender pauses until every expected word has come
    drain();
    // long receiver hold-off while faces keep coming
    hold_recv = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_recv = 1'b0;
      end
      for (int k = 0; k < 4; k++) send_random(-1, 1'b1, k == 3);
    join
    for (int n = 0; n < N_RANDOM; n += glen) begin
      if (n >= N_RANDOM / 3 && send_idle_pct == 10) begin
        send_idle_pct = 76;
        recv_idle_pct = 10;
      end else if (n >= 2 * N_RANDOM / 3 && send_idle_pct != 0) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      glen = $urandom_range(12, 1);
      for (int k = 0; k < glen; k++)
        send_random(($urandom_range(9) == 0) ? -1 : $urandom_range(4),
                    $urandom_range(9) != 0, k == glen - 1 || $urandom_range(40) == 0);
    end
    drain();
    $display("checked %0d words: %0d triangles over %0d groups, mixed stalls",
             sb.checked, sb.triangles, sb.groups);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
